@@ src/ieds_pkg.sv @@
`default_nettype none

package ieds_pkg;

  // Default largest frame side in pixels.
  localparam int MAX_DIMENSION_DEF = 256;

  // Fixed field widths.
  localparam int COLOUR_W  = 24;
  localparam int LUMA_W    = 22;
  localparam int RATIO_W   = 17;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int DIST_W    = 18;
  localparam int SQ_W      = 2 * LUMA_W;
  localparam int EDGE_SQ_W = SQ_W + 1;
  localparam int SLOPE_W   = LUMA_W + 3;
  localparam int NUM_RATIOS = 6;
  localparam int DIV_STEP_W = 5;

  // Colour distance classes and the luma edge threshold (42 squared, 1/10000 units).
  localparam logic [DIST_W-1:0]    FLAT_LIMIT    = 18'd16;
  localparam logic [DIST_W-1:0]    SOFT_LIMIT    = 18'd784;
  localparam logic [EDGE_SQ_W-1:0] EDGE_LIMIT_SQ = 45'd176400000000;
  localparam logic [RATIO_W-1:0]   ONE_Q16       = 17'h10000;
  localparam logic [CFG_W-1:0]     DIM_RESET     = 9'd256;

  // Luma weights in units of 1/10000.
  localparam logic [LUMA_W-1:0] LUMA_R = 22'd2126;
  localparam logic [LUMA_W-1:0] LUMA_G = 22'd7152;
  localparam logic [LUMA_W-1:0] LUMA_B = 22'd722;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    RATIO_FLAT,
    RATIO_SOFT,
    RATIO_STRONG,
    RATIO_DENSITY,
    RATIO_HORIZ,
    RATIO_VERT
  } ratio_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_RIGHT,
    ST_RD_LEFT,
    ST_PAIR_LEFT,
    ST_PAIR_UP,
    ST_SQ_DY,
    ST_EDGE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_pix;
    logic       rd_right;
    logic       rd_left;
    logic       cap_centre;
    logic       cap_right;
    logic       pair_left;
    logic       pair_up;
    logic       sq_dy;
    logic       edge_step;
    logic       div_start;
    ratio_sel_t div_sel;
    logic       clear_counts;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_pixel;
    logic div_done;
  } ctrl_status_t;

  // Luma of a packed RGB pixel.
  function automatic logic [LUMA_W-1:0] luma_of(input logic [COLOUR_W-1:0] pix);
    luma_of = LUMA_W'(pix[23:16]) * LUMA_R + LUMA_W'(pix[15:8]) * LUMA_G +
              LUMA_W'(pix[7:0]) * LUMA_B;
  endfunction

  // Squared colour distance between two packed RGB pixels.
  function automatic logic [DIST_W-1:0] colour_dist(input logic [COLOUR_W-1:0] a,
                                                    input logic [COLOUR_W-1:0] b);
    logic [7:0] dr, dg, db;
    dr = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
    dg = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
    db = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
    colour_dist = DIST_W'(dr) * DIST_W'(dr) + DIST_W'(dg) * DIST_W'(dg) +
                  DIST_W'(db) * DIST_W'(db);
  endfunction

endpackage

`default_nettype wire

@@ src/ieds_divider.sv @@
`default_nettype none

module ieds_divider #(
  parameter int CW = 17
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [CW-1:0]               count,
  input  wire logic [CW-1:0]               total,
  output logic                             done,
  output logic [ieds_pkg::RATIO_W-1:0]     quotient
);
  import ieds_pkg::*;

  localparam int NW = CW + RATIO_W;

  logic [NW-1:0]         rem_r, den_r;
  logic [RATIO_W-1:0]    quo_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic                  busy_r, done_r;
  logic                  fits;

  assign fits = (rem_r >= den_r);

  // Restoring division: one quotient bit a cycle, rounded by adding half the divisor first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + DIV_STEP_W'(1);
        if (step_r == DIV_STEP_W'(RATIO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, count, 16'h0000} + NW'(total >> 1);
      den_r <= NW'(total) << 16;
      quo_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - den_r;
      end
      quo_r <= {quo_r[RATIO_W-2:0], fits};
      den_r <= den_r >> 1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ src/ieds_ctrl.sv @@
`default_nettype none

module ieds_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  input  wire ieds_pkg::ctrl_status_t status,
  output ieds_pkg::ctrl_cmd_t         cmd
);
  import ieds_pkg::*;

  state_t     state_r, state_nxt;
  ratio_sel_t sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= RATIO_FLAT;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_RD_RIGHT;
      ST_RD_RIGHT:  state_nxt = ST_RD_LEFT;
      ST_RD_LEFT:   state_nxt = ST_PAIR_LEFT;
      ST_PAIR_LEFT: state_nxt = ST_PAIR_UP;
      ST_PAIR_UP:   state_nxt = ST_SQ_DY;
      ST_SQ_DY:     state_nxt = ST_EDGE;
      ST_EDGE: begin
        sel_nxt   = RATIO_FLAT;
        state_nxt = status.last_pixel ? ST_DIV_LOAD : ST_IDLE;
      end
      ST_DIV_LOAD:  state_nxt = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (status.div_done) begin
          if (sel_r == RATIO_VERT) begin
            state_nxt = ST_OUT;
          end else begin
            sel_nxt   = ratio_sel_t'(sel_r + 3'd1);
            state_nxt = ST_DIV_LOAD;
          end
        end
      end
      ST_OUT:       if (!out_stall) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd         = '0;
    cmd.div_sel = sel_r;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_pix = in_valid;
      end
      ST_RD_RIGHT: begin
        cmd.cap_centre = 1'b1;
        cmd.rd_right   = 1'b1;
      end
      ST_RD_LEFT: begin
        cmd.cap_right = 1'b1;
        cmd.rd_left   = 1'b1;
      end
      ST_PAIR_LEFT: cmd.pair_left = 1'b1;
      ST_PAIR_UP:   cmd.pair_up   = 1'b1;
      ST_SQ_DY:     cmd.sq_dy     = 1'b1;
      ST_EDGE:      cmd.edge_step = 1'b1;
      ST_DIV_LOAD:  cmd.div_start = 1'b1;
      ST_DIV_RUN:   ;
      ST_OUT: begin
        out_valid        = 1'b1;
        cmd.clear_counts = !out_stall;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/ieds_datapath.sv @@
`default_nettype none

module ieds_datapath #(
  parameter int MAX_DIMENSION = ieds_pkg::MAX_DIMENSION_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ieds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ieds_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic [7:0]                      in_red,
  input  wire logic [7:0]                      in_green,
  input  wire logic [7:0]                      in_blue,
  input  wire ieds_pkg::ctrl_cmd_t             cmd,
  output ieds_pkg::ctrl_status_t               status,
  output logic [ieds_pkg::RATIO_W-1:0]         out_flat_ratio,
  output logic [ieds_pkg::RATIO_W-1:0]         out_soft_change_ratio,
  output logic [ieds_pkg::RATIO_W-1:0]         out_strong_edge_ratio,
  output logic [ieds_pkg::RATIO_W-1:0]         out_edge_density,
  output logic [ieds_pkg::RATIO_W-1:0]         out_horizontal_edge_ratio,
  output logic [ieds_pkg::RATIO_W-1:0]         out_vertical_edge_ratio
);
  import ieds_pkg::*;

  localparam int PW = $clog2(MAX_DIMENSION);
  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int CW = $clog2(2 * MAX_DIMENSION * MAX_DIMENSION);
  localparam int MW = COLOUR_W + 2 * LUMA_W;

  // Configuration and frame position.
  logic [CFG_W-1:0] width_cfg_r, height_cfg_r;
  logic [PW-1:0]    x_r, y_r;
  logic [DW-1:0]    w_dim, h_dim;
  logic [PW:0]      x_p1, y_p1;
  logic             last_col, last_row, has_left, has_up, do_check;

  // Line store: colour of the row above, luma of the rows one and two above.
  logic [MW-1:0]    line_mem [MAX_DIMENSION];
  logic [MW-1:0]    rd_data_r;
  logic [PW-1:0]    rd_addr;

  // Pixel working registers.
  logic [COLOUR_W-1:0] pix_r, left_colour_r, up_col_r;
  logic [LUMA_W-1:0]   luma_r, near_x_r, far_x_r, near_right_r, far_left;
  logic [LUMA_W-1:0]   dx_r, dy_r;
  logic [LUMA_W-1:0]   sq_in;
  logic [SQ_W-1:0]     sq_out;
  logic [SQ_W-1:0]     sq_dx_r, sq_dy_r;
  logic [EDGE_SQ_W-1:0] grad_sq;
  logic [SLOPE_W-1:0]  dx5, dx6, dy5, dy6;
  logic [DIST_W-1:0]   col_dist;

  // Frame counters.
  logic [CW-1:0] pair_r, flat_r, soft_r, strong_r, checked_r, edges_r, horiz_r, vert_r;

  // Division operands and results.
  logic [CW-1:0]       div_num, div_den;
  logic                div_done;
  logic [RATIO_W-1:0]  div_quo;
  logic [RATIO_W-1:0]  ratio_r [NUM_RATIOS];

  // Clamp the configured sides to 1..MAX_DIMENSION.
  always_comb begin
    if (width_cfg_r == '0) begin
      w_dim = DW'(1);
    end else if (32'(width_cfg_r) > 32'(MAX_DIMENSION)) begin
      w_dim = DW'(MAX_DIMENSION);
    end else begin
      w_dim = DW'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      h_dim = DW'(1);
    end else if (32'(height_cfg_r) > 32'(MAX_DIMENSION)) begin
      h_dim = DW'(MAX_DIMENSION);
    end else begin
      h_dim = DW'(height_cfg_r);
    end
  end

  // Position flags for the current pixel.
  assign x_p1     = {1'b0, x_r} + (PW + 1)'(1);
  assign y_p1     = {1'b0, y_r} + (PW + 1)'(1);
  assign last_col = (x_p1 >= (PW + 1)'(w_dim));
  assign last_row = (y_p1 >= (PW + 1)'(h_dim));
  assign has_left = (x_r != '0);
  assign has_up   = (y_r != '0);
  assign do_check = (y_r >= PW'(2)) && has_left && !last_col;

  assign status.last_pixel = last_col && last_row;
  assign status.div_done   = div_done;

  // Read address: this column, or its right or left neighbour.
  always_comb begin
    rd_addr = x_r;
    if (cmd.rd_right) begin
      rd_addr = x_r + PW'(1);
    end else if (cmd.rd_left) begin
      rd_addr = x_r - PW'(1);
    end
  end

  // Line store, one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (cmd.edge_step) begin
      line_mem[x_r] <= {pix_r, luma_r, near_x_r};
    end
    rd_data_r <= line_mem[rd_addr];
  end

  assign far_left = rd_data_r[LUMA_W-1:0];
  assign col_dist = colour_dist(cmd.pair_left ? left_colour_r : up_col_r, pix_r);
  assign grad_sq  = EDGE_SQ_W'(sq_dx_r) + EDGE_SQ_W'(sq_dy_r);
  assign dx5      = (SLOPE_W'(dx_r) << 2) + SLOPE_W'(dx_r);
  assign dx6      = (SLOPE_W'(dx_r) << 2) + (SLOPE_W'(dx_r) << 1);
  assign dy5      = (SLOPE_W'(dy_r) << 2) + SLOPE_W'(dy_r);
  assign dy6      = (SLOPE_W'(dy_r) << 2) + (SLOPE_W'(dy_r) << 1);

  // One squarer serves both gradient components on successive cycles.
  assign sq_in  = cmd.sq_dy ? dy_r : dx_r;
  assign sq_out = sq_in * sq_in;

  // Pixel working registers, one step per controller command.
  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      pix_r <= {in_red, in_green, in_blue};
    end
    if (cmd.cap_centre) begin
      up_col_r <= rd_data_r[MW-1 -: COLOUR_W];
      near_x_r <= rd_data_r[2*LUMA_W-1 -: LUMA_W];
      far_x_r  <= rd_data_r[LUMA_W-1:0];
      luma_r   <= luma_of(pix_r);
    end
    if (cmd.cap_right) begin
      near_right_r <= rd_data_r[2*LUMA_W-1 -: LUMA_W];
    end
    if (cmd.pair_left) begin
      dx_r <= (near_right_r > far_left) ? near_right_r - far_left : far_left - near_right_r;
      dy_r <= (luma_r > far_x_r) ? luma_r - far_x_r : far_x_r - luma_r;
    end
    if (cmd.pair_up) begin
      sq_dx_r <= sq_out;
    end
    if (cmd.sq_dy) begin
      sq_dy_r <= sq_out;
    end
  end

  // Configuration, position and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r   <= DIM_RESET;
      height_cfg_r  <= DIM_RESET;
      x_r           <= '0;
      y_r           <= '0;
      left_colour_r <= '0;
      pair_r        <= '0;
      flat_r        <= '0;
      soft_r        <= '0;
      strong_r      <= '0;
      checked_r     <= '0;
      edges_r       <= '0;
      horiz_r       <= '0;
      vert_r        <= '0;
    end else if (cfg_wr_en || cmd.clear_counts) begin
      if (cfg_wr_en) begin
        case (cfg_index_t'(cfg_index))
          CFG_FRAME_WIDTH:  width_cfg_r  <= cfg_data;
          CFG_FRAME_HEIGHT: height_cfg_r <= cfg_data;
          default: ;
        endcase
        x_r <= '0;
        y_r <= '0;
      end
      pair_r    <= '0;
      flat_r    <= '0;
      soft_r    <= '0;
      strong_r  <= '0;
      checked_r <= '0;
      edges_r   <= '0;
      horiz_r   <= '0;
      vert_r    <= '0;
    end else begin
      // Classify the left pair, then the upper pair, by colour distance.
      if ((cmd.pair_left && has_left) || (cmd.pair_up && has_up)) begin
        pair_r <= pair_r + CW'(1);
        if (col_dist <= FLAT_LIMIT) begin
          flat_r <= flat_r + CW'(1);
        end else if (col_dist <= SOFT_LIMIT) begin
          soft_r <= soft_r + CW'(1);
        end else begin
          strong_r <= strong_r + CW'(1);
        end
      end
      // Gradient test, line store update and raster advance.
      if (cmd.edge_step) begin
        if (do_check) begin
          checked_r <= checked_r + CW'(1);
          if (grad_sq >= EDGE_LIMIT_SQ) begin
            edges_r <= edges_r + CW'(1);
            if (dy5 > dx6) begin
              horiz_r <= horiz_r + CW'(1);
            end else if (dx5 > dy6) begin
              vert_r <= vert_r + CW'(1);
            end
          end
        end
        left_colour_r <= pix_r;
        if (!last_col) begin
          x_r <= x_p1[PW-1:0];
        end else begin
          x_r <= '0;
          y_r <= last_row ? '0 : y_p1[PW-1:0];
        end
      end
    end
  end

  // Operands of the ratio being worked out.
  always_comb begin
    case (cmd.div_sel)
      RATIO_FLAT:    begin div_num = flat_r;   div_den = pair_r;    end
      RATIO_SOFT:    begin div_num = soft_r;   div_den = pair_r;    end
      RATIO_STRONG:  begin div_num = strong_r; div_den = pair_r;    end
      RATIO_DENSITY: begin div_num = edges_r;  div_den = checked_r; end
      RATIO_HORIZ:   begin div_num = horiz_r;  div_den = edges_r;   end
      RATIO_VERT:    begin div_num = vert_r;   div_den = edges_r;   end
      default:       begin div_num = '0;       div_den = '0;        end
    endcase
  end

  ieds_divider #(
    .CW(CW)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .count    (div_num),
    .total    (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Store each ratio; an empty total gives zero, or one for flat with no pairs.
  always_ff @(posedge clk) begin
    if (div_done) begin
      if (div_den == '0) begin
        ratio_r[cmd.div_sel] <= (cmd.div_sel == RATIO_FLAT) ? ONE_Q16 : '0;
      end else begin
        ratio_r[cmd.div_sel] <= div_quo;
      end
    end
  end

  assign out_flat_ratio            = ratio_r[RATIO_FLAT];
  assign out_soft_change_ratio     = ratio_r[RATIO_SOFT];
  assign out_strong_edge_ratio     = ratio_r[RATIO_STRONG];
  assign out_edge_density          = ratio_r[RATIO_DENSITY];
  assign out_horizontal_edge_ratio = ratio_r[RATIO_HORIZ];
  assign out_vertical_edge_ratio   = ratio_r[RATIO_VERT];

endmodule

`default_nettype wire

@@ src/image_neighbour_edge_statistics_core.sv @@
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_red, in_green, in_blue (8 bits each)
// out_      output     out_valid/out_stall six Q1.16 ratios, 17 bits each
// cfg_      input      cfg_wr_en          cfg_index, cfg_data (9 bits)
//
// Each pixel is first accepted, then needs three line-store reads through
// the single read port of the line memory and the gradient squares on one shared
// multiplier; no new pixel is accepted until it is through. After the last pixel of a
// frame the shared divider works out the six ratios in turn, and the result item waits
// until taken; no pixel is accepted meanwhile. Reset is synchronous and active low; it needs
// no clearing pass, as the line memory is read only where written in the same frame.
`default_nettype none

module image_neighbour_edge_statistics_core #(
  parameter int MAX_DIMENSION = ieds_pkg::MAX_DIMENSION_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ieds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ieds_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_red,
  input  wire logic [7:0]                      in_green,
  input  wire logic [7:0]                      in_blue,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [ieds_pkg::RATIO_W-1:0]         out_flat_ratio,
  output logic [ieds_pkg::RATIO_W-1:0]         out_soft_change_ratio,
  output logic [ieds_pkg::RATIO_W-1:0]         out_strong_edge_ratio,
  output logic [ieds_pkg::RATIO_W-1:0]         out_edge_density,
  output logic [ieds_pkg::RATIO_W-1:0]         out_horizontal_edge_ratio,
  output logic [ieds_pkg::RATIO_W-1:0]         out_vertical_edge_ratio
);
  import ieds_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer.
  ieds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Line store, counters and divider.
  ieds_datapath #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_datapath (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_wr_en                 (cfg_wr_en),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data),
    .in_red                    (in_red),
    .in_green                  (in_green),
    .in_blue                   (in_blue),
    .cmd                       (cmd),
    .status                    (status),
    .out_flat_ratio            (out_flat_ratio),
    .out_soft_change_ratio     (out_soft_change_ratio),
    .out_strong_edge_ratio     (out_strong_edge_ratio),
    .out_edge_density          (out_edge_density),
    .out_horizontal_edge_ratio (out_horizontal_edge_ratio),
    .out_vertical_edge_ratio   (out_vertical_edge_ratio)
  );

endmodule

`default_nettype wire

@@ src/ieds_checker.sv @@
`default_nettype none

module ieds_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic [ieds_pkg::RATIO_W-1:0]    out_flat_ratio,
  input  wire logic [ieds_pkg::RATIO_W-1:0]    out_soft_change_ratio,
  input  wire logic [ieds_pkg::RATIO_W-1:0]    out_strong_edge_ratio,
  input  wire logic [ieds_pkg::RATIO_W-1:0]    out_edge_density,
  input  wire logic [ieds_pkg::RATIO_W-1:0]    out_horizontal_edge_ratio,
  input  wire logic [ieds_pkg::RATIO_W-1:0]    out_vertical_edge_ratio
);
  import ieds_pkg::*;

  // A waiting result item stays valid, with its flat and vertical ratios stable, until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_flat_ratio) &&
    $stable(out_vertical_edge_ratio))
    else $error("result item changed while stalled");

  // No ratio exceeds one.
  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_flat_ratio <= ONE_Q16 && out_soft_change_ratio <= ONE_Q16 &&
    out_strong_edge_ratio <= ONE_Q16 && out_edge_density <= ONE_Q16 &&
    out_horizontal_edge_ratio <= ONE_Q16 && out_vertical_edge_ratio <= ONE_Q16)
    else $error("ratio above one");

  // No pixel is taken while a result item waits.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("pixel accepted while result pending");

  // An accepted pixel keeps the block busy in the next cycle.
  a_busy_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("pixel accepted on consecutive cycles");

  // Reset leaves no result item.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item after reset");

endmodule

bind image_neighbour_edge_statistics_core ieds_checker u_ieds_checker (.*);

`default_nettype wire
